// ----- hw/rtl/fgd_pkg.sv -----
// Shared constants, types and gate helpers for the filter geometry decoder.
package fgd_pkg;

    localparam int NUM_BANDS  = 32;
    localparam int KEY_FRAMES = 128;

    localparam int IDW  = 16;                     // filter number width
    localparam int TNW  = $clog2(2 * KEY_FRAMES); // holds a time length and its successor
    localparam int BW   = $clog2(NUM_BANDS + 1);  // band counters
    localparam int GW   = BW + 3;                 // group size: positions times types
    localparam int TWO  = 10;                     // output time width
    localparam int BWO  = 7;                      // output band width / start band
    localparam int STW  = 3;                      // output shape type

    // Shared subtract/compare unit result.
    typedef struct packed {
        logic [IDW-1:0] diff;
        logic           gt;
    } t_alu_res;

    // Bit k set when type k+1 is counted at this time length and band width.
    function automatic logic [5:0] gate_mask(input logic t_gt1, input logic t_gt3,
                                             input logic wb_gt1, input logic wb_gt3);
        gate_mask = {wb_gt3, t_gt3, t_gt1 & wb_gt1, wb_gt1, t_gt1, 1'b1};
    endfunction

    function automatic logic [2:0] mask_count(input logic [5:0] mask);
        logic [2:0] cnt;
        cnt = '0;
        for (int k = 0; k < 6; k++) begin
            cnt = cnt + 3'(mask[k]);
        end
        mask_count = cnt;
    endfunction

    // Type number of the n-th enabled gate, n one-based.
    function automatic logic [STW-1:0] nth_type(input logic [5:0] mask, input logic [2:0] n);
        logic [2:0]     cnt;
        logic [STW-1:0] res;
        cnt = '0;
        res = '0;
        for (int k = 0; k < 6; k++) begin
            cnt = cnt + 3'(mask[k]);
            if (mask[k] && cnt == n && res == '0) begin
                res = STW'(k + 1);
            end
        end
        nth_type = res;
    endfunction

endpackage

// ----- hw/rtl/fgd_alu.sv -----
// Shared subtract and compare unit used by every step of the walk.
module fgd_alu (
    input  logic [fgd_pkg::IDW-1:0] i_a,
    input  logic [fgd_pkg::IDW-1:0] i_b,
    output fgd_pkg::t_alu_res       o_res
);

    always_comb begin
        o_res.diff = i_a - i_b;
        o_res.gt   = i_a > i_b;
    end

endmodule

// ----- hw/rtl/fgd_next_time.sv -----
// Next time length: 1.5*t rounded up to even, at least t+1.
module fgd_next_time (
    input  logic [fgd_pkg::TNW-1:0] i_t,
    output logic [fgd_pkg::TNW-1:0] o_next
);

    logic [fgd_pkg::TNW+1:0] half;
    logic [fgd_pkg::TNW+1:0] rnd;
    logic [fgd_pkg::TNW+1:0] inc;

    always_comb begin
        half   = ((fgd_pkg::TNW+2)'(i_t) * (fgd_pkg::TNW+2)'(3) + (fgd_pkg::TNW+2)'(1)) >> 1;
        rnd    = half + (fgd_pkg::TNW+2)'(half[0]);
        inc    = (fgd_pkg::TNW+2)'(i_t) + (fgd_pkg::TNW+2)'(1);
        o_next = (rnd > inc) ? rnd[fgd_pkg::TNW-1:0] : inc[fgd_pkg::TNW-1:0];
    end

endmodule

// ----- hw/rtl/filter_id_to_geometry_decoder.sv -----
// Top level: filter number to filter geometry decoder with a sequenced walk.
// Pulse start with a filter number while busy is low; busy rises the next cycle and
// the result word appears on the o_ result ports for exactly one cycle, marked by
// o_valid, as busy falls. The receiver cannot stall, so capture it in that cycle.
// The walk steps one (time length, band width) group per cycle through a single
// shared subtract/compare unit, then steps start bands inside the matching group on
// the same unit. With 32 bands and 128 key frames there are 11*32 = 352 groups.
// A new word can be taken at the edge that ends the result cycle. Number zero or
// any number past the last filter gives found=0 and zero fields.
module filter_id_to_geometry_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [fgd_pkg::IDW-1:0]    i_filter_number,
    output logic                       busy,
    output logic                       o_valid,
    output logic                       o_found,
    output logic [fgd_pkg::TWO-1:0]    o_time_width,
    output logic [fgd_pkg::BWO-1:0]    o_band_width,
    output logic [fgd_pkg::BWO-1:0]    o_start_band,
    output logic [fgd_pkg::STW-1:0]    o_shape_type
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,   // skip whole groups while the remainder exceeds the group size
        S_DIV     // step start bands inside the matching group
    } t_state;

    t_state                    r_state, n_state;
    logic [fgd_pkg::IDW-1:0]   r_rem, n_rem;   // filters left to count, one-based
    logic [fgd_pkg::TNW-1:0]   r_t, n_t;
    logic [fgd_pkg::BW-1:0]    r_wb, n_wb;
    logic [fgd_pkg::BW-1:0]    r_fb, n_fb;
    logic                      r_valid, n_valid;
    logic                      r_found, n_found;
    logic [fgd_pkg::TWO-1:0]   r_tw, n_tw;
    logic [fgd_pkg::BWO-1:0]   r_bw, n_bw;
    logic [fgd_pkg::BWO-1:0]   r_sb, n_sb;
    logic [fgd_pkg::STW-1:0]   r_st, n_st;

    logic [5:0]                mask;
    logic [2:0]                g;
    logic [fgd_pkg::BW-1:0]    positions;
    logic [fgd_pkg::GW-1:0]    gsize;
    logic [fgd_pkg::IDW-1:0]   alu_b;
    fgd_pkg::t_alu_res         alu;
    logic [fgd_pkg::TNW-1:0]   t_next;

    // Types counted at each position of the current group, and group size.
    always_comb begin
        mask      = fgd_pkg::gate_mask(r_t > fgd_pkg::TNW'(1), r_t > fgd_pkg::TNW'(3),
                                       r_wb > fgd_pkg::BW'(1), r_wb > fgd_pkg::BW'(3));
        g         = fgd_pkg::mask_count(mask);
        positions = fgd_pkg::BW'(fgd_pkg::NUM_BANDS + 1) - r_wb;
        gsize     = fgd_pkg::GW'(positions) * fgd_pkg::GW'(g);
        alu_b     = (r_state == S_DIV) ? fgd_pkg::IDW'(g) : fgd_pkg::IDW'(gsize);
    end

    fgd_alu u_alu (
        .i_a   (r_rem),
        .i_b   (alu_b),
        .o_res (alu)
    );

    fgd_next_time u_next_time (
        .i_t    (r_t),
        .o_next (t_next)
    );

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_t     = r_t;
        n_wb    = r_wb;
        n_fb    = r_fb;
        n_valid = 1'b0;
        n_found = r_found;
        n_tw    = r_tw;
        n_bw    = r_bw;
        n_sb    = r_sb;
        n_st    = r_st;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_rem   = i_filter_number;
                    n_t     = fgd_pkg::TNW'(1);
                    n_wb    = fgd_pkg::BW'(1);
                    n_fb    = fgd_pkg::BW'(1);
                end
            end
            S_SCAN: begin
                if (r_rem == '0) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_tw    = '0;
                    n_bw    = '0;
                    n_sb    = '0;
                    n_st    = '0;
                end else if (alu.gt) begin
                    n_rem = alu.diff;
                    if (r_wb == fgd_pkg::BW'(fgd_pkg::NUM_BANDS)) begin
                        n_wb = fgd_pkg::BW'(1);
                        if (t_next >= fgd_pkg::TNW'(fgd_pkg::KEY_FRAMES)) begin
                            // ran off the end of the enumeration
                            n_state = S_IDLE;
                            n_valid = 1'b1;
                            n_found = 1'b0;
                            n_tw    = '0;
                            n_bw    = '0;
                            n_sb    = '0;
                            n_st    = '0;
                        end else begin
                            n_t = t_next;
                        end
                    end else begin
                        n_wb = r_wb + fgd_pkg::BW'(1);
                    end
                end else begin
                    n_state = S_DIV;
                    n_fb    = fgd_pkg::BW'(1);
                end
            end
            S_DIV: begin
                if (alu.gt) begin
                    n_rem = alu.diff;
                    n_fb  = r_fb + fgd_pkg::BW'(1);
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_tw    = fgd_pkg::TWO'(r_t);
                    n_bw    = fgd_pkg::BWO'(r_wb);
                    n_sb    = fgd_pkg::BWO'(r_fb);
                    n_st    = fgd_pkg::nth_type(mask, r_rem[2:0]);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_found <= n_found;
        end
        r_rem <= n_rem;
        r_t   <= n_t;
        r_wb  <= n_wb;
        r_fb  <= n_fb;
        r_tw  <= n_tw;
        r_bw  <= n_bw;
        r_sb  <= n_sb;
        r_st  <= n_st;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_time_width = r_tw;
    assign o_band_width = r_bw;
    assign o_start_band = r_sb;
    assign o_shape_type = r_st;

`ifndef SYNTHESIS
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    a_valid_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result word outside the end of a walk");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_time_width == '0 && o_band_width == '0 &&
                                   o_start_band == '0 && o_shape_type == '0))
        else $error("not-found word carries nonzero fields");

    a_found_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_shape_type != '0 && o_shape_type <= 3'd6 &&
                                  o_time_width != '0 && o_band_width != '0 &&
                                  o_start_band != '0))
        else $error("found word with bad shape type or zero geometry");

    a_found_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |->
            ((8'(o_start_band) + 8'(o_band_width)) <= 8'(fgd_pkg::NUM_BANDS + 1)))
        else $error("found filter runs past the last band");
`endif

endmodule

// ----- sim/filter_id_to_geometry_decoder_test.sv -----
// Self-checking testbench for the filter number to geometry decoder.
module filter_id_to_geometry_decoder_test;

    // One decoded result word, laid out like the result ports.
    typedef struct packed {
        logic                      found;
        logic [fgd_pkg::TWO-1:0]   time_w;
        logic [fgd_pkg::BWO-1:0]   band_w;
        logic [fgd_pkg::BWO-1:0]   start_b;
        logic [fgd_pkg::STW-1:0]   shape;
    } t_geometry;

    // A filter number waiting to be sent, with the sender idle rate of its phase.
    typedef struct {
        logic [fgd_pkg::IDW-1:0] number;
        int unsigned             idle_pct;
    } t_request;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 450;   // worst-case walk plus margin
    localparam int PHASE_ITEMS  = 350;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [fgd_pkg::IDW-1:0]    i_filter_number = '0;
    logic                       busy;
    logic                       o_valid;
    logic                       o_found;
    logic [fgd_pkg::TWO-1:0]    o_time_width;
    logic [fgd_pkg::BWO-1:0]    o_band_width;
    logic [fgd_pkg::BWO-1:0]    o_start_band;
    logic [fgd_pkg::STW-1:0]    o_shape_type;

    t_request            pending_q[$];     // numbers still to be sent
    t_geometry           geometry_q[$];    // decoded words still owed by the block
    t_geometry           want;
    logic                item_taken = 1'b0;
    int unsigned         fail_count = 0;
    int unsigned         sent_count = 0;
    int unsigned         hit_count = 0;
    int unsigned         miss_count = 0;

    filter_id_to_geometry_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_filter_number (i_filter_number),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_time_width    (o_time_width),
        .o_band_width    (o_band_width),
        .o_start_band    (o_start_band),
        .o_shape_type    (o_shape_type)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------

    // Time lengths grow by 1.5x, rounded up to even, and by at least one.
    function automatic int unsigned next_length(input int unsigned t);
        int unsigned r;
        int unsigned c;
        r = (3 * t + 1) >> 1;
        c = r + (r & 1);
        return (c > t + 1) ? c : t + 1;
    endfunction

    // Bit k set when shape type k+1 exists at this time length and band width.
    function automatic logic [5:0] shape_gates(input int unsigned t, input int unsigned wb);
        logic [5:0] g;
        g[0] = 1'b1;
        g[1] = t > 1;
        g[2] = wb > 1;
        g[3] = (t > 1) && (wb > 1);
        g[4] = t > 3;
        g[5] = wb > 3;
        return g;
    endfunction

    // Number of filters in the whole enumeration.
    function automatic int unsigned filter_total();
        int unsigned n;
        n = 0;
        for (int unsigned t = 1; t < fgd_pkg::KEY_FRAMES; t = next_length(t))
            for (int unsigned wb = 1; wb <= fgd_pkg::NUM_BANDS; wb++)
                n += (fgd_pkg::NUM_BANDS - wb + 1) * $countones(shape_gates(t, wb));
        return n;
    endfunction

    // Skip whole (time, width) groups, then index into the matching one:
    // start bands are outer, shape types inner.
    function automatic t_geometry decode_filter(input logic [fgd_pkg::IDW-1:0] number);
        t_geometry   g;
        logic [5:0]  gates;
        int unsigned rem;
        int unsigned n_types;
        int unsigned group;
        int          slot;
        g = '0;
        if (number == '0)
            return g;
        rem = number - 1;
        for (int unsigned t = 1; t < fgd_pkg::KEY_FRAMES; t = next_length(t)) begin
            for (int unsigned wb = 1; wb <= fgd_pkg::NUM_BANDS; wb++) begin
                gates   = shape_gates(t, wb);
                n_types = $countones(gates);
                group   = (fgd_pkg::NUM_BANDS - wb + 1) * n_types;
                if (rem < group) begin
                    g.found   = 1'b1;
                    g.time_w  = fgd_pkg::TWO'(t);
                    g.band_w  = fgd_pkg::BWO'(wb);
                    g.start_b = fgd_pkg::BWO'(rem / n_types + 1);
                    slot = int'(rem % n_types);
                    for (int k = 0; k < 6; k++) begin
                        if (gates[k]) begin
                            if (slot == 0)
                                g.shape = fgd_pkg::STW'(k + 1);
                            slot--;
                        end
                    end
                    return g;
                end
                rem -= group;
            end
        end
        return g;   // past the end of the enumeration
    endfunction

    // Mostly numbers that name a filter, some around the end, some anywhere.
    function automatic logic [fgd_pkg::IDW-1:0] pick_number(input int unsigned total);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return fgd_pkg::IDW'($urandom_range(total, 1));
        else if (r < 88)
            return fgd_pkg::IDW'($urandom_range(total + 8, total - 8));
        else
            return fgd_pkg::IDW'($urandom_range((1 << fgd_pkg::IDW) - 1, 0));
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A number stays on the
    // port with start high until the block takes it (start && !busy).
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // hold the word until it is taken
        end else if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
            start           <= 1'b1;
            i_filter_number <= pending_q[0].number;
            void'(pending_q.pop_front());
        end else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge. The result word of the previous
    // number may come in the same cycle a new one is taken, so the check
    // pops before the new expectation is queued.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            if (geometry_q.size() == 0) begin
                $error("result word with no filter number outstanding");
                fail_count++;
            end else begin
                want = geometry_q.pop_front();
                check_field("found",      32'(want.found),   32'(o_found));
                check_field("time_width", 32'(want.time_w),  32'(o_time_width));
                check_field("band_width", 32'(want.band_w),  32'(o_band_width));
                check_field("start_band", 32'(want.start_b), 32'(o_start_band));
                check_field("shape_type", 32'(want.shape),   32'(o_shape_type));
                if (want.found)
                    hit_count++;
                else
                    miss_count++;
            end
        end
        if (i_rst_n && start && !busy) begin
            geometry_q.insert(geometry_q.size(), decode_filter(i_filter_number));
            sent_count++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned total;
        int unsigned idle_rate[4];
        logic [fgd_pkg::IDW-1:0] directed[$];
        t_request req;

        total     = filter_total();
        idle_rate = '{0, 63, 0, 26};

        // Directed: zero, first filters, last band at width one, first wide
        // band (type 6), time length group borders, type 4 and type 5 firsts,
        // the end of the enumeration, top bit and alternating bit patterns.
        directed = '{16'd0, 16'd1, 16'd2, 16'd32, 16'd33, 16'd155, 16'd156, 16'd157,
                     16'd1459, 16'd1460, 16'd1524, 16'd1525, 16'd1526, 16'd1527,
                     16'd3942, 16'd3943, 16'd3944, 16'd3945,
                     fgd_pkg::IDW'(total - 1), fgd_pkg::IDW'(total),
                     fgd_pkg::IDW'(total + 1),
                     16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA};
        foreach (directed[i]) begin
            req.number   = directed[i];
            req.idle_pct = 0;
            pending_q.insert(pending_q.size(), req);
        end

        // Random phases, each with its own sender idle rate.
        foreach (idle_rate[p])
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                req.number   = pick_number(total);
                req.idle_pct = idle_rate[p];
                pending_q.insert(pending_q.size(), req);
            end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || geometry_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d filter numbers across four sender idle phases:", sent_count);
        $display("  %0d named a filter, %0d were zero or past the last of %0d.",
                 hit_count, miss_count, total);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #36_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fgd_pkg.sv
hw/rtl/fgd_alu.sv
hw/rtl/fgd_next_time.sv
hw/rtl/filter_id_to_geometry_decoder.sv
sim/filter_id_to_geometry_decoder_test.sv
